// ===== hw/rtl/contour_edge_finder_top_assert.svh =====
// Assertion helpers for the RTL files; only ctef_back includes them.
`ifndef CONTOUR_EDGE_FINDER_TOP_ASSERT_SVH
`define CONTOUR_EDGE_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define CTEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CTEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ctef_pkg.sv =====
package ctef_pkg;

    localparam int IN_W    = 16;
    localparam int ID_W    = 8;
    localparam int DIST_W  = 2 * IN_W + 1;
    localparam int Q_DEPTH = 4;

    typedef logic [1:0] t_kind;

    localparam t_kind K_REF  = 2'd0;
    localparam t_kind K_PT   = 2'd1;
    localparam t_kind K_LAST = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] y;
        logic [IN_W-1:0] x;
    } t_pt;

    typedef struct packed {
        t_kind           kind;
        t_pt             pt;
        logic [ID_W-1:0] cid;
    } t_item;

    // distance pipe output toward the compare logic
    typedef struct packed {
        logic              v;
        logic              tag;
        t_pt               pt;
        logic [DIST_W-1:0] dsq;
    } t_dres;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_pt             start_pt;
        t_pt             end_pt;
        logic            ovf;
    } t_res;

endpackage

// ===== hw/rtl/ctef_if.sv =====
interface ctef_in_if import ctef_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            mode;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic [ID_W-1:0] contour_id;
    logic            last_point;

    modport source (output valid, mode, x, y, contour_id, last_point, input ready);
    modport sink   (input valid, mode, x, y, contour_id, last_point, output ready);
endinterface

interface ctef_out_if import ctef_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] result_id;
    logic [IN_W-1:0] start_x;
    logic [IN_W-1:0] start_y;
    logic [IN_W-1:0] end_x;
    logic [IN_W-1:0] end_y;
    logic            overflow;

    modport source (output valid, result_id, start_x, start_y, end_x, end_y, overflow,
                    input ready);
    modport sink   (input valid, result_id, start_x, start_y, end_x, end_y, overflow,
                    output ready);
endinterface

// ===== hw/rtl/ctef_ram.sv =====
module ctef_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ctef_dist.sv =====
module ctef_dist import ctef_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_v,
    input  logic  i_tag,
    input  t_pt   i_a,
    input  t_pt   i_b,
    output t_dres o_res,
    output logic  o_busy
);

    logic              r_v1, r_v2;
    logic              r_tag1, r_tag2;
    t_pt               r_pt1, r_pt2;
    logic [IN_W-1:0]   r_dx, r_dy;
    logic [2*IN_W-1:0] r_sqx, r_sqy;
    logic [IN_W-1:0]   n_dx, n_dy;

    always_comb begin
        n_dx = (i_a.x > i_b.x) ? (i_a.x - i_b.x) : (i_b.x - i_a.x);
        n_dy = (i_a.y > i_b.y) ? (i_a.y - i_b.y) : (i_b.y - i_a.y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_v;
            r_v2 <= r_v1;
        end
        r_tag1 <= i_tag;
        r_pt1  <= i_a;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_tag2 <= r_tag1;
        r_pt2  <= r_pt1;
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
    end

    always_comb begin
        o_res.v   = r_v2;
        o_res.tag = r_tag2;
        o_res.pt  = r_pt2;
        o_res.dsq = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    assign o_busy = r_v1 | r_v2;

endmodule

// ===== hw/rtl/ctef_front.sv =====
module ctef_front import ctef_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctef_in_if.sink        i_in,
    output logic           o_head_v,
    output t_item          o_head,
    input  logic           i_pop
);

    localparam int QAW = $clog2(Q_DEPTH);
    localparam logic [IN_W-1:0] CMASK = (COORD_BITS >= IN_W) ? {IN_W{1'b1}} :
        IN_W'((32'd1 << COORD_BITS) - 32'd1);

    t_item          r_q [Q_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push;
    t_item          n_item;

    assign i_in.ready = (r_cnt != (QAW+1)'(Q_DEPTH));
    assign push       = i_in.valid & i_in.ready;

    always_comb begin
        n_item.pt.x = i_in.x & CMASK;
        n_item.pt.y = i_in.y & CMASK;
        n_item.cid  = i_in.contour_id;
        if (!i_in.mode) begin
            n_item.kind = K_REF;
        end else if (i_in.last_point) begin
            n_item.kind = K_LAST;
        end else begin
            n_item.kind = K_PT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    assign o_head_v = (r_cnt != '0);
    assign o_head   = r_q[r_rp];

endmodule

// ===== hw/rtl/ctef_back.sv =====
`include "contour_edge_finder_top_assert.svh"

module ctef_back import ctef_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_v,
    input  t_item      i_head,
    output logic       o_pop,
    ctef_out_if.source o_out
);

    localparam int CW   = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_RUN    = 3'd0;
    localparam logic [2:0] S_DRAIN1 = 3'd1;
    localparam logic [2:0] S_P2     = 3'd2;
    localparam logic [2:0] S_DRAIN2 = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]        r_state, n_state;
    t_pt               r_ref, n_ref;
    t_pt               r_end, n_end;
    logic [DIST_W-1:0] r_end_d, n_end_d;
    logic              r_have, n_have;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [ID_W-1:0]   r_cid, n_cid;
    t_pt               r_start, n_start;
    logic [DIST_W-1:0] r_start_d, n_start_d;
    logic [CNTW-1:0]   r_idx, n_idx;
    logic              r_rd_v;
    t_res              r_out, n_out;
    logic              r_out_v, n_out_v;

    logic              head_is_ref, pipe_busy, issue1, has_room;
    logic              ram_we, ram_re, load_out;
    logic [2*CW-1:0]   ram_rdata;
    t_pt               rd_pt, d_a, d_b;
    t_dres             d_res;
    logic              upd1, upd2;

    assign head_is_ref = (i_head.kind == K_REF);
    assign has_room    = (r_cnt < CNTW'(MAX_POINTS));
    assign o_pop       = (r_state == S_RUN) && i_head_v && (!head_is_ref || !pipe_busy);
    assign issue1      = o_pop && !head_is_ref;
    assign ram_we      = issue1 && has_room;
    assign ram_re      = (r_state == S_P2) && (r_idx < r_cnt);
    assign load_out    = (r_state == S_FIN) && (!r_out_v || o_out.ready);

    ctef_ram #(
        .W     (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_head.pt.y[CW-1:0], i_head.pt.x[CW-1:0]}),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rd_pt.x = IN_W'(ram_rdata[CW-1:0]);
        rd_pt.y = IN_W'(ram_rdata[2*CW-1:CW]);
        // second pass measures against the end, first pass against the reference
        d_a     = r_rd_v ? rd_pt : i_head.pt;
        d_b     = r_rd_v ? r_end : r_ref;
    end

    ctef_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (issue1 | r_rd_v),
        .i_tag   (r_rd_v),
        .i_a     (d_a),
        .i_b     (d_b),
        .o_res   (d_res),
        .o_busy  (pipe_busy)
    );

    assign upd1 = d_res.v && !d_res.tag && (!r_have || (d_res.dsq > r_end_d));
    assign upd2 = d_res.v && d_res.tag && (d_res.dsq > r_start_d);

    always_comb begin
        n_state   = r_state;
        n_ref     = r_ref;
        n_end     = r_end;
        n_end_d   = r_end_d;
        n_have    = r_have;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_cid     = r_cid;
        n_start   = r_start;
        n_start_d = r_start_d;
        n_idx     = r_idx;
        n_out     = r_out;
        n_out_v   = r_out_v;

        if (upd1) begin
            n_end   = d_res.pt;
            n_end_d = d_res.dsq;
            n_have  = 1'b1;
        end
        if (upd2) begin
            n_start   = d_res.pt;
            n_start_d = d_res.dsq;
        end
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_RUN: begin
                if (o_pop) begin
                    if (head_is_ref) begin
                        n_ref   = i_head.pt;
                        n_cnt   = '0;
                        n_have  = 1'b0;
                        n_end   = '0;
                        n_end_d = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_cid = i_head.cid;
                        if (has_room) begin
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_head.kind == K_LAST) begin
                            n_state = S_DRAIN1;
                        end
                    end
                end
            end
            S_DRAIN1: begin
                if (!pipe_busy) begin
                    n_start   = r_end;
                    n_start_d = '0;
                    n_idx     = '0;
                    n_state   = S_P2;
                end
            end
            S_P2: begin
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_DRAIN2;
                end
            end
            S_DRAIN2: begin
                if (!r_rd_v && !pipe_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (load_out) begin
                    n_out.id       = r_cid;
                    n_out.start_pt = r_start;
                    n_out.end_pt   = r_end;
                    n_out.ovf      = r_ovf;
                    n_out_v        = 1'b1;
                    n_ref          = r_end;
                    n_cnt          = '0;
                    n_have         = 1'b0;
                    n_end          = '0;
                    n_end_d        = '0;
                    n_ovf          = 1'b0;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_ref   <= '0;
            r_end   <= '0;
            r_end_d <= '0;
            r_have  <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_end   <= n_end;
            r_end_d <= n_end_d;
            r_have  <= n_have;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_rd_v  <= ram_re;
            r_out_v <= n_out_v;
        end
        r_cid     <= n_cid;
        r_start   <= n_start;
        r_start_d <= n_start_d;
        r_idx     <= n_idx;
        r_out     <= n_out;
    end

    assign o_out.valid     = r_out_v;
    assign o_out.result_id = r_out.id;
    assign o_out.start_x   = r_out.start_pt.x;
    assign o_out.start_y   = r_out.start_pt.y;
    assign o_out.end_x     = r_out.end_pt.x;
    assign o_out.end_y     = r_out.end_pt.y;
    assign o_out.overflow  = r_out.ovf;

    `CTEF_ASSERT_IMP(a_pop_has_word, i_clk, i_rst_n, o_pop, i_head_v)
    `CTEF_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNTW'(MAX_POINTS))
    `CTEF_ASSERT_IMP(a_p2_tag_state, i_clk, i_rst_n, d_res.v && d_res.tag,
                     r_state == S_P2 || r_state == S_DRAIN2)
    `CTEF_ASSERT_IMP(a_fin_drained, i_clk, i_rst_n, r_state == S_FIN, !pipe_busy && !r_rd_v)
    `CTEF_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, load_out, r_out_v && r_state == S_RUN)

endmodule

// ===== hw/rtl/contour_edge_finder_top.sv =====
// Contour edge finder. Each input word is either a reference load (mode 0) or one
// contour point (mode 1). Points are scored against the reference as they arrive,
// one per clock while the back end is in its run state, in a two-stage
// squared-distance pipe, and stored in a point RAM of MAX_POINTS entries.
// The last point of a contour starts a second pass that reads every stored
// point once from that RAM; a reference word waits for in-flight points to
// drain. A 4-word queue sits between the input and the scoring logic, and the
// result sits in an output register, so the input keeps taking words while a
// result waits. The store needs no clearing after reset. Points past MAX_POINTS
// still count for the end point but are not stored, and the result's overflow
// flag is set.
module contour_edge_finder_top import ctef_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctef_in_if.sink     i_in,
    ctef_out_if.source  o_out
);

    logic  head_v;
    t_item head;
    logic  pop;

    ctef_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_head_v (head_v),
        .o_head   (head),
        .i_pop    (pop)
    );

    ctef_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (head_v),
        .i_head   (head),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
